// File: rtl/baro_pkg.sv
// Shared types, constants and helpers for the barometer compensation block.
`default_nettype none

package baro_pkg;

    // Depth of the queue between the temperature front end and the pressure back end.
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Configuration register indexes.
    localparam logic [1:0] REG_TEMP    = 2'd0;
    localparam logic [1:0] REG_PRESS_A = 2'd1;
    localparam logic [1:0] REG_PRESS_B = 2'd2;
    localparam logic [1:0] REG_PRESS_C = 2'd3;

    // Arithmetic constants of the compensation formulas.
    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [20:0] P_BASE      = 21'd1048576;
    localparam logic [63:0] K_SCALE     = 64'd3125;
    localparam logic [63:0] V1_BIAS     = 64'h0000_8000_0000_0000;

    // One queue entry: the temperature results and the raw pressure of one item.
    typedef struct packed {
        logic signed [31:0] fine;
        logic signed [31:0] temp_centi;
        logic [19:0]        raw_p;
    } q_entry_t;

    // Sign extension of a 16-bit calibration word to 64 bits.
    function automatic logic [63:0] sext16(input logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

endpackage

`default_nettype wire

// File: rtl/baro_front.sv
// Temperature front end: accepts items and computes fine temperature and centidegrees.
`default_nettype none

module baro_front
    import baro_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [19:0]        raw_t,
    input  wire logic [19:0]        raw_p,
    input  wire logic [15:0]        t1,
    input  wire logic signed [15:0] t2,
    input  wire logic signed [15:0] t3,
    input  wire logic               q_full,
    output logic                    q_push,
    output q_entry_t                q_data
);

    logic en;
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;

    logic signed [17:0] d1;
    logic signed [16:0] d2;
    logic signed [33:0] d1t2_next;
    logic signed [33:0] dsq_next;
    logic signed [20:0] sq_hi;
    logic signed [36:0] tbp_next;
    logic signed [22:0] tb;
    logic signed [31:0] fine_next;
    logic signed [35:0] t5;

    logic signed [33:0] d1t2_reg;
    logic [31:0]        dsq_reg;
    logic signed [22:0] ta_reg;
    logic signed [36:0] tbp_reg;
    logic signed [31:0] fine3_reg, fine4_reg;
    logic signed [31:0] tc_reg;
    logic [19:0]        rp1_reg, rp2_reg, rp3_reg, rp4_reg;

    // The whole pipeline moves unless its last stage holds an item the queue cannot take.
    assign en       = !(vld4_reg && q_full);
    assign in_ready = en;
    assign q_push   = vld4_reg && !q_full;

    // Stage one operands and products.
    assign d1        = {1'b0, raw_t[19:3]} - {1'b0, t1, 1'b0};
    assign d2        = {1'b0, raw_t[19:4]} - {1'b0, t1};
    assign d1t2_next = d1 * t2;
    assign dsq_next  = d2 * d2;

    // Stage two: scaled square times T3.
    assign sq_hi    = $signed({1'b0, dsq_reg[31:12]});
    assign tbp_next = sq_hi * t3;

    // Stage three: fine temperature.
    assign tb        = tbp_reg[36:14];
    assign fine_next = 32'(ta_reg) + 32'(tb);

    // Stage four: hundredths of a degree, (fine * 5 + 128) >> 8.
    assign t5 = (36'(fine3_reg) <<< 2) + 36'(fine3_reg) + 36'sd128;

    // Valid flags of the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    // Payload of the stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            d1t2_reg  <= d1t2_next;
            dsq_reg   <= dsq_next[31:0];
            rp1_reg   <= raw_p;
            ta_reg    <= d1t2_reg[33:11];
            tbp_reg   <= tbp_next;
            rp2_reg   <= rp1_reg;
            fine3_reg <= fine_next;
            rp3_reg   <= rp2_reg;
            fine4_reg <= fine3_reg;
            tc_reg    <= 32'($signed(t5[35:8]));
            rp4_reg   <= rp3_reg;
        end
    end

    assign q_data.fine       = fine4_reg;
    assign q_data.temp_centi = tc_reg;
    assign q_data.raw_p      = rp4_reg;

endmodule

`default_nettype wire

// File: rtl/baro_queue.sv
// Short first-in first-out queue between the front end and the back end.
`default_nettype none

module baro_queue
    import baro_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire q_entry_t wr_data,
    input  wire logic     pop,
    output logic          full,
    output logic          not_empty,
    output q_entry_t      rd_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    q_entry_t        mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/baro_div.sv
// Signed 64-bit divider, truncating toward zero, one quotient bit per cycle.
`default_nettype none

module baro_div
    import baro_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [63:0] den,
    output logic             done,
    output logic [63:0]      quot
);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIX  = 3'b100
    } div_state_t;

    div_state_t  state_reg, state_next;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic [63:0] q_reg, r_reg, mb_reg;
    logic [64:0] trial;
    logic [64:0] diff;

    // Restoring step: shift in the next dividend bit and try a subtraction.
    assign trial = {r_reg, q_reg[63]};
    assign diff  = trial - {1'b0, mb_reg};

    assign done = (state_reg == D_FIX);
    assign quot = neg_reg ? (64'd0 - q_reg) : q_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: if (start) state_next = D_RUN;
            D_RUN:  if (cnt_reg == 6'd63) state_next = D_FIX;
            D_FIX:  state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Magnitudes at the start, then one bit per cycle.
    always_ff @(posedge aclk) begin
        if (state_reg == D_IDLE && start) begin
            neg_reg <= num[63] ^ den[63];
            q_reg   <= num[63] ? (64'd0 - num) : num;
            mb_reg  <= den[63] ? (64'd0 - den) : den;
            r_reg   <= '0;
            cnt_reg <= '0;
        end else if (state_reg == D_RUN) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (!diff[64]) begin
                r_reg <= diff[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end else begin
                r_reg <= trial[63:0];
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/baro_back.sv
// Pressure back end: 64-bit compensation on a shared 32x32 multiplier and a divider.
`default_nettype none

module baro_back
    import baro_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire q_entry_t    q_data,
    output logic             q_pop,
    input  wire logic [15:0] p1,
    input  wire logic [15:0] p2,
    input  wire logic [15:0] p3,
    input  wire logic [15:0] p4,
    input  wire logic [15:0] p5,
    input  wire logic [15:0] p6,
    input  wire logic [15:0] p7,
    input  wire logic [15:0] p8,
    input  wire logic [15:0] p9,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_tc,
    output logic [31:0]      out_q,
    output logic [23:0]      out_pa,
    output logic             out_err
);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_MUL  = 5'b00010,
        B_DIV  = 5'b00100,
        B_FIN  = 5'b01000,
        B_OUT  = 5'b10000
    } back_state_t;

    // Multiplication steps of the pressure formula, in order.
    typedef enum logic [3:0] {
        OP_SQ, OP_P6, OP_P5, OP_P3, OP_P2, OP_P1, OP_K, OP_P9, OP_PS, OP_P8
    } op_t;

    // Cycles of one 64-bit product.
    localparam logic [2:0] PH_LL  = 3'd0;
    localparam logic [2:0] PH_HL  = 3'd1;
    localparam logic [2:0] PH_LH  = 3'd2;
    localparam logic [2:0] PH_ACC = 3'd3;
    localparam logic [2:0] PH_END = 3'd4;

    back_state_t state_reg;
    op_t         op_reg;
    logic [2:0]  phase_reg;

    logic [63:0] v1_reg, sq_reg, v2_reg, x_reg, y_reg, p_reg, w_reg;
    logic [63:0] macc_reg, pp_reg, res_q_reg;
    logic        res_err_reg;
    logic [19:0] rawp_reg;
    logic [31:0] tc_reg;

    logic [63:0] op_a, op_b, ps;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_out;
    logic [63:0] x_p1;
    logic [63:0] w2_sh, y_sh;
    logic [20:0] p0;
    logic        div_start, div_done;
    logic [63:0] div_quot;
    logic        out_free;

    // Arithmetic right shifts, each kept on its own so the sign is not lost in a sum.
    assign ps       = $signed(p_reg) >>> 13;
    assign x_p1     = $signed(macc_reg) >>> 33;
    assign w2_sh    = $signed(macc_reg) >>> 19;
    assign y_sh     = $signed(y_reg) >>> 8;
    assign p0       = P_BASE - {1'b0, rawp_reg};
    assign out_free = !out_valid || out_ready;
    assign q_pop    = (state_reg == B_IDLE) && q_valid;
    assign div_start = (state_reg == B_MUL) && (phase_reg == PH_END) && (op_reg == OP_K);

    // Operand selection for the current step.
    always_comb begin
        unique case (op_reg)
            OP_SQ: begin op_a = v1_reg;      op_b = v1_reg;      end
            OP_P6: begin op_a = sq_reg;      op_b = sext16(p6);  end
            OP_P5: begin op_a = v1_reg;      op_b = sext16(p5);  end
            OP_P3: begin op_a = sq_reg;      op_b = sext16(p3);  end
            OP_P2: begin op_a = v1_reg;      op_b = sext16(p2);  end
            OP_P1: begin op_a = x_reg;       op_b = {48'd0, p1}; end
            OP_K:  begin op_a = y_reg;       op_b = K_SCALE;     end
            OP_P9: begin op_a = sext16(p9);  op_b = ps;          end
            OP_PS: begin op_a = y_reg;       op_b = ps;          end
            OP_P8: begin op_a = sext16(p8);  op_b = p_reg;       end
            default: begin op_a = '0;        op_b = '0;          end
        endcase
    end

    // One shared 32x32 multiplier; the halves are chosen by the phase.
    assign mul_a   = (phase_reg == PH_HL) ? op_a[63:32] : op_a[31:0];
    assign mul_b   = (phase_reg == PH_LH) ? op_b[63:32] : op_b[31:0];
    assign mul_out = {32'd0, mul_a} * {32'd0, mul_b};

    baro_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (macc_reg),
        .den     (x_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            op_reg    <= OP_SQ;
            phase_reg <= PH_LL;
        end else begin
            unique case (state_reg)
                B_IDLE: begin
                    if (q_valid) begin
                        state_reg <= B_MUL;
                        op_reg    <= OP_SQ;
                        phase_reg <= PH_LL;
                    end
                end
                B_MUL: begin
                    if (phase_reg == PH_END) begin
                        phase_reg <= PH_LL;
                        unique case (op_reg)
                            OP_SQ: op_reg <= OP_P6;
                            OP_P6: op_reg <= OP_P5;
                            OP_P5: op_reg <= OP_P3;
                            OP_P3: op_reg <= OP_P2;
                            OP_P2: op_reg <= OP_P1;
                            OP_P1: begin
                                if (x_p1 == '0) begin
                                    state_reg <= B_OUT;
                                end else begin
                                    op_reg <= OP_K;
                                end
                            end
                            OP_K:  state_reg <= B_DIV;
                            OP_P9: op_reg <= OP_PS;
                            OP_PS: op_reg <= OP_P8;
                            OP_P8: state_reg <= B_FIN;
                            default: state_reg <= B_IDLE;
                        endcase
                    end else begin
                        phase_reg <= phase_reg + 1'b1;
                    end
                end
                B_DIV: begin
                    if (div_done) begin
                        state_reg <= B_MUL;
                        op_reg    <= OP_P9;
                        phase_reg <= PH_LL;
                    end
                end
                B_FIN: state_reg <= B_OUT;
                B_OUT: if (out_free) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (state_reg == B_IDLE && q_valid) begin
            v1_reg      <= {{32{q_data.fine[31]}}, q_data.fine} - FINE_OFFSET;
            tc_reg      <= q_data.temp_centi;
            rawp_reg    <= q_data.raw_p;
            res_err_reg <= 1'b0;
        end
        if (state_reg == B_MUL) begin
            unique case (phase_reg)
                PH_LL:  pp_reg <= mul_out;
                PH_HL: begin
                    macc_reg <= pp_reg;
                    pp_reg   <= mul_out;
                end
                PH_LH: begin
                    macc_reg <= macc_reg + {pp_reg[31:0], 32'd0};
                    pp_reg   <= mul_out;
                end
                PH_ACC: macc_reg <= macc_reg + {pp_reg[31:0], 32'd0};
                PH_END: begin
                    unique case (op_reg)
                        OP_SQ: sq_reg <= macc_reg;
                        OP_P6: v2_reg <= macc_reg;
                        OP_P5: v2_reg <= v2_reg + (macc_reg << 17) + (sext16(p4) << 35);
                        OP_P3: x_reg  <= $signed(macc_reg) >>> 8;
                        OP_P2: x_reg  <= x_reg + (macc_reg << 12) + V1_BIAS;
                        OP_P1: begin
                            x_reg <= x_p1;
                            y_reg <= ({43'd0, p0} << 31) - v2_reg;
                            if (x_p1 == '0) begin
                                res_err_reg <= 1'b1;
                                res_q_reg   <= '0;
                            end
                        end
                        OP_P9: y_reg <= macc_reg;
                        OP_PS: w_reg <= $signed(macc_reg) >>> 25;
                        OP_P8: y_reg <= p_reg + w_reg + w2_sh;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        if (state_reg == B_DIV && div_done) begin
            p_reg <= div_quot;
        end
        if (state_reg == B_FIN) begin
            res_q_reg <= y_sh + (sext16(p7) << 4);
        end
    end

    // Output register: a finished result waits here while the next item starts.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (state_reg == B_OUT && out_free) begin
            out_valid <= 1'b1;
        end else if (out_ready) begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_OUT && out_free) begin
            out_tc  <= tc_reg;
            out_q   <= res_q_reg[31:0];
            out_pa  <= res_q_reg[31:8];
            out_err <= res_err_reg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/barometer_compensation_int64.sv
// Top level of the barometer compensation block: ports, calibration registers, assertions.
//
// Each input transfer carries one raw temperature and one raw pressure sample and yields one
// result transfer. The temperature front end is a four-stage pipeline that takes a transfer every
// cycle unless a full queue holds its last stage, and places its results in a four-entry queue.
// The pressure back end works on one item at a time: ten 64-bit products on a shared 32x32
// multiplier and a signed divider; a zero divisor skips the divider and the last four products.
// The back end therefore sets the sustained rate; the front end pipeline, the queue, the back end
// and the output register absorb bursts of up to ten items. Calibration words must be written
// through the cfg port only while the block is idle; the block itself does not enforce this.
`default_nettype none

module barometer_compensation_int64
    import baro_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // raw_temperature [19:0], raw_pressure [39:20]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // temperature_centi [31:0], pressure_q24_8 [63:32],
                                        // pressure_pa [87:64], divide_error [88], zero above
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_wdata
);

    logic [47:0] temp_coeffs_reg, press_a_reg, press_b_reg, press_c_reg;
    q_entry_t    front_data, head_data;
    logic        q_push, q_pop, q_full;
    logic        q_not_empty;
    logic [31:0] out_tc, out_q;
    logic [23:0] out_pa;
    logic        out_err;

    // Calibration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg <= '0;
            press_a_reg     <= '0;
            press_b_reg     <= '0;
            press_c_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TEMP:    temp_coeffs_reg <= cfg_wdata;
                REG_PRESS_A: press_a_reg     <= cfg_wdata;
                REG_PRESS_B: press_b_reg     <= cfg_wdata;
                REG_PRESS_C: press_c_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    baro_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .raw_t    (s_tdata[19:0]),
        .raw_p    (s_tdata[39:20]),
        .t1       (temp_coeffs_reg[15:0]),
        .t2       ($signed(temp_coeffs_reg[31:16])),
        .t3       ($signed(temp_coeffs_reg[47:32])),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (front_data)
    );

    baro_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wr_data   (front_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .rd_data   (head_data)
    );

    baro_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_not_empty),
        .q_data    (head_data),
        .q_pop     (q_pop),
        .p1        (press_a_reg[15:0]),
        .p2        (press_a_reg[31:16]),
        .p3        (press_a_reg[47:32]),
        .p4        (press_b_reg[15:0]),
        .p5        (press_b_reg[31:16]),
        .p6        (press_b_reg[47:32]),
        .p7        (press_c_reg[15:0]),
        .p8        (press_c_reg[31:16]),
        .p9        (press_c_reg[47:32]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tc    (out_tc),
        .out_q     (out_q),
        .out_pa    (out_pa),
        .out_err   (out_err)
    );

    assign m_tdata = {7'd0, out_err, out_pa, out_q, out_tc};

`ifndef SYNTHESIS
    // The front end never writes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue written while full");

    // A divide error result carries zero pressure.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[88]) |-> (m_tdata[87:32] == '0))
        else $error("divide error with nonzero pressure");

    // Whole pascals are the Q24.8 value without its fraction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[87:64] == m_tdata[63:40]))
        else $error("pressure fields disagree");
`endif

endmodule

`default_nettype wire

// File: bench/baro_checker.sv
// Checker for the barometer compensation block: predicts each result and compares it.
`default_nettype none

module baro_checker
    import baro_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,   // raw_temperature [19:0], raw_pressure [39:20]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [95:0] m_tdata,   // temperature_centi [31:0], pressure_q24_8 [63:32],
                                        // pressure_pa [87:64], divide_error [88]
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_wdata,
    output int               fail_count,
    output int               pending,
    output int               results_seen,
    output int               div_err_seen
);

    // Members from the highest bits down, matching the result tdata layout.
    typedef struct packed {
        logic               div_err;
        logic [23:0]        pa;
        logic [31:0]        q24_8;
        logic signed [31:0] centi;
    } baro_result_t;

    logic [47:0]  cal_temp, cal_a, cal_b, cal_c;
    baro_result_t expected_results[$];

    // Compensation of one sample pair with the given calibration words.
    function automatic baro_result_t compensate(input logic [19:0] raw_t,
                                                input logic [19:0] raw_p,
                                                input logic [47:0] ct, input logic [47:0] ca,
                                                input logic [47:0] cb, input logic [47:0] cc);
        logic signed [63:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] d1, d2, ta, tb, fine, centi, v1, v2, p, ps, w1, w2, num, sh;
        logic signed [31:0] fine32;
        logic [63:0]        mag_n, mag_d, quo;
        baro_result_t       res;
        adc_t = {44'd0, raw_t};
        adc_p = {44'd0, raw_p};
        t1 = {48'd0, ct[15:0]};
        t2 = {{48{ct[31]}}, ct[31:16]};
        t3 = {{48{ct[47]}}, ct[47:32]};
        p1 = {48'd0, ca[15:0]};
        p2 = {{48{ca[31]}}, ca[31:16]};
        p3 = {{48{ca[47]}}, ca[47:32]};
        p4 = {{48{cb[15]}}, cb[15:0]};
        p5 = {{48{cb[31]}}, cb[31:16]};
        p6 = {{48{cb[47]}}, cb[47:32]};
        p7 = {{48{cc[15]}}, cc[15:0]};
        p8 = {{48{cc[31]}}, cc[31:16]};
        p9 = {{48{cc[47]}}, cc[47:32]};

        // Temperature: the fine value wraps in 32 bits.
        d1 = (adc_t >>> 3) - (t1 <<< 1);
        ta = (d1 * t2) >>> 11;
        d2 = (adc_t >>> 4) - t1;
        tb = (((d2 * d2) >>> 12) * t3) >>> 14;
        fine32 = 32'(ta + tb);
        fine = fine32;
        centi = (fine * 5 + 128) >>> 8;

        // Pressure divisor and dividend offset.
        v1 = fine - 128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = ((64'sh0000_8000_0000_0000 + v1) * p1) >>> 33;

        res.centi = centi[31:0];
        res.q24_8 = '0;
        res.pa = '0;
        res.div_err = 1'b0;
        if (v1 == 0) begin
            res.div_err = 1'b1;
        end else begin
            p = 1048576 - adc_p;
            num = ((p <<< 31) - v2) * 3125;
            // Signed division by magnitudes, truncating toward zero.
            mag_n = num[63] ? 64'd0 - num : num;
            mag_d = v1[63] ? 64'd0 - v1 : v1;
            quo = mag_n / mag_d;
            p = (num[63] ^ v1[63]) ? 64'd0 - quo : quo;
            ps = p >>> 13;
            w1 = (p9 * ps * ps) >>> 25;
            w2 = (p8 * p) >>> 19;
            p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
            sh = p >>> 8;
            res.q24_8 = p[31:0];
            res.pa = sh[23:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
                 results_seen);
        fail_count++;
    endtask

    // Track calibration writes, predict on input transfers, compare on result transfers.
    always @(posedge aclk) begin
        baro_result_t want, got;
        if (!aresetn) begin
            cal_temp <= '0;
            cal_a <= '0;
            cal_b <= '0;
            cal_c <= '0;
            expected_results.delete();
            fail_count = 0;
            results_seen = 0;
            div_err_seen = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TEMP:    cal_temp <= cfg_wdata;
                    REG_PRESS_A: cal_a <= cfg_wdata;
                    REG_PRESS_B: cal_b <= cfg_wdata;
                    REG_PRESS_C: cal_c <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(compensate(s_tdata[19:0], s_tdata[39:20],
                                                      cal_temp, cal_a, cal_b, cal_c));
            if (m_tvalid && m_tready) begin
                got = m_tdata[88:0];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result transfer", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.centi !== want.centi)
                        report_mismatch("temperature_centi", got.centi, want.centi);
                    if (got.q24_8 !== want.q24_8)
                        report_mismatch("pressure_q24_8", got.q24_8, want.q24_8);
                    if (got.pa !== want.pa)
                        report_mismatch("pressure_pa", got.pa, want.pa);
                    if (got.div_err !== want.div_err)
                        report_mismatch("divide_error", got.div_err, want.div_err);
                    if (m_tdata[95:89] !== '0)
                        report_mismatch("padding", m_tdata[95:89], 0);
                    if (want.div_err)
                        div_err_seen++;
                end
                results_seen++;
            end
        end
        pending = expected_results.size();
    end

endmodule

`default_nettype wire

// File: bench/tb_barometer_compensation_int64.sv
// Testbench top for the barometer compensation block: stimulus, calibration phases, verdict.
`default_nettype none

module tb_barometer_compensation_int64
    import baro_pkg::*;
;

    localparam int CYCLE_LIMIT = 2000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_TEMP;
    logic [47:0] cfg_wdata = '0;
    int          fail_count, pending, results_seen, div_err_seen;
    int          cycles = 0;
    int          items_sent = 0;
    bit          no_idle = 1'b0;

    barometer_compensation_int64 uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    baro_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending),
        .results_seen(results_seen), .div_err_seen(div_err_seen)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // The result side stalls at random unless idling is switched off.
    always @(negedge aclk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 27);
    end

    // One input transfer, preceded by random idle cycles.
    task automatic send_sample(input logic [19:0] raw_t, input logic [19:0] raw_p);
        while (!no_idle && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {raw_p, raw_t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Calibration is written only once every result has arrived and the block has settled.
    task automatic write_calibration(input logic [47:0] ct, input logic [47:0] ca,
                                     input logic [47:0] cb, input logic [47:0] cc);
        logic [47:0] vals [4];
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
        vals = '{ct, ca, cb, cc};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 2'(i);
            cfg_wdata <= vals[i];
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_sample(20'($urandom), 20'($urandom));
    endtask

    function automatic logic [47:0] rand_word48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // A typical factory calibration set, with small random offsets on every word.
    function automatic logic [47:0] jitter(input logic [47:0] w);
        logic [47:0] r;
        for (int k = 0; k < 3; k++)
            r[16*k +: 16] = w[16*k +: 16] + 16'($urandom_range(64)) - 16'd32;
        return r;
    endfunction

    localparam logic [47:0] TYP_T = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [47:0] TYP_A = {16'd3024, 16'hD643, 16'd36477};
    localparam logic [47:0] TYP_B = {16'hFFF9, 16'd140, 16'd2855};
    localparam logic [47:0] TYP_C = {16'd6000, 16'hC6F8, 16'd15500};

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset calibration: the divisor is zero, so every pressure result is an error.
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h7E9D0, 20'h655AC);

        // Typical calibration with extreme and ordinary samples.
        write_calibration(TYP_T, TYP_A, TYP_B, TYP_C);
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hFFFFF, 20'h00000);
        send_sample(20'h00000, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'd519888, 20'd415148);
        send_sample(20'h80000, 20'h80000);
        send_sample(20'h7FFFF, 20'h00001);

        // All-ones calibration words.
        write_calibration('1, '1, '1, '1);
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'd519888, 20'd415148);

        // Most negative signed words, largest unsigned ones.
        write_calibration({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'hFFFF},
                          {3{16'h8000}}, {3{16'h8000}});
        send_sample(20'h00000, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'h00000);
        send_sample(20'd519888, 20'd415148);

        // Zero pressure scale alone forces the divisor to zero.
        write_calibration(TYP_T, {TYP_A[47:16], 16'd0}, TYP_B, TYP_C);
        send_sample(20'd519888, 20'd415148);
        send_sample(20'hFFFFF, 20'hFFFFF);

        // Random phases: jittered typical and random sets, an all-zero set; one phase without idling.
        write_calibration(jitter(TYP_T), jitter(TYP_A), jitter(TYP_B), jitter(TYP_C));
        send_random(350);
        no_idle = 1'b1;
        write_calibration(jitter(TYP_T), jitter(TYP_A), jitter(TYP_B), jitter(TYP_C));
        send_random(300);
        no_idle = 1'b0;
        write_calibration(rand_word48(), rand_word48(), rand_word48(), rand_word48());
        send_random(300);
        write_calibration(rand_word48(), rand_word48() & 48'hFFFF_FFFF_0000,
                          rand_word48(), rand_word48());
        send_random(100);
        write_calibration(rand_word48(), rand_word48(), rand_word48(), rand_word48());
        send_random(250);
        write_calibration('0, '0, '0, '0);
        send_random(50);
        write_calibration(jitter(TYP_T), jitter(TYP_A), jitter(TYP_B), jitter(TYP_C));
        send_random(200);
        s_tvalid <= 1'b0;

        // Drain, then allow the block time to show any stray result.
        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);

        $display("Sent %0d sample pairs over 12 calibration settings; %0d results checked,",
                 items_sent, results_seen);
        $display("%0d of them with a zero pressure divisor.", div_err_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/baro_pkg.sv
rtl/baro_front.sv
rtl/baro_queue.sv
rtl/baro_div.sv
rtl/baro_back.sv
rtl/barometer_compensation_int64.sv
bench/baro_checker.sv
bench/tb_barometer_compensation_int64.sv
